FILE: hw/rtl/ssm_pkg.sv
// Shared types and constants for the 3x3 stencil smoother.
// No dependencies; used by ssm_front, ssm_mac and the top level.
`timescale 1ns / 1ps
`default_nettype none
package ssm_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int WIDTH_W   = 13;
	localparam int PIX_W     = 16;
	localparam int WEIGHT_W  = 18;
	localparam int SUM_W     = PIX_W + 2;
	localparam int PROD_W    = WEIGHT_W + SUM_W + 1;
	localparam int TOTAL_W   = PROD_W + 3;
	localparam int LINE_W    = 2 * PIX_W;
	localparam int PADDR_W   = 4;

	localparam logic [WIDTH_W-1:0] WIDTH_MIN   = WIDTH_W'(3);
	localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(16);

	localparam logic signed [WEIGHT_W-1:0] CORNER_RESET = WEIGHT_W'(3277);
	localparam logic signed [WEIGHT_W-1:0] EDGE_RESET   = WEIGHT_W'(6554);
	localparam logic signed [WEIGHT_W-1:0] CENTRE_RESET = WEIGHT_W'(26214);

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH   = 2'd0,
		REG_CORNER_WEIGHT = 2'd1,
		REG_EDGE_WEIGHT   = 2'd2,
		REG_CENTRE_WEIGHT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [WEIGHT_W-1:0] corner;
		logic signed [WEIGHT_W-1:0] edge_w;
		logic signed [WEIGHT_W-1:0] centre;
	} weights_t;

	typedef struct packed {
		logic [SUM_W-1:0] corners;
		logic [SUM_W-1:0] edges;
		logic [PIX_W-1:0] centre;
		logic             last;
	} taps_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ssm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ssm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/ssm_front.sv
// Front end: position counters, line buffer RAM, 3x3 window and neighbour sums.
// Depends on ssm_pkg and ssm_ram.
`timescale 1ns / 1ps
`default_nettype none
module ssm_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [ssm_pkg::PIX_W-1:0]      pixel,
	input  wire logic                           frame_start,
	input  wire logic [ssm_pkg::WIDTH_W-1:0]    eff_width,
	input  wire logic                           take_s2,
	output logic                                valid_s2,
	output ssm_pkg::taps_t                      taps_s2
);

	localparam int AW = ssm_pkg::ADDR_W;
	localparam int WW = ssm_pkg::WIDTH_W;
	localparam int PW = ssm_pkg::PIX_W;
	localparam int SW = ssm_pkg::SUM_W;
	localparam int LW = ssm_pkg::LINE_W;

	logic [AW-1:0] row_q, col_q;
	logic          accept, go_s2;
	logic [WW-1:0] col_start, row_start, row_adv, row_cur, col_cur, col_inc, row_inc;
	logic          col_wrap;
	logic          emit, last;

	logic          valid_s1, emit_s1, last_s1, fwd_s1;
	logic [AW-1:0] addr_s1;
	logic [PW-1:0] px_s1;
	logic [LW-1:0] fwd_data_s1;

	logic [LW-1:0] ram_rdata, rd_eff, wdata;
	logic [PW-1:0] up_rd, mid_rd;
	logic          we;

	logic [PW-1:0] win_q [3][3];

	assign go_s2    = !valid_s2 || take_s2;
	assign in_ready = !valid_s1 || go_s2;
	assign accept   = in_valid && in_ready;

	always_comb begin
		col_start = frame_start ? '0 : WW'(col_q);
		row_start = frame_start ? '0 : WW'(row_q);
		col_wrap  = col_start >= eff_width;
		col_cur   = col_wrap ? '0 : col_start;
		row_adv   = col_wrap ? row_start + WW'(1) : row_start;
		row_cur   = (row_adv >= eff_width) ? '0 : row_adv;
		emit      = (row_cur >= WW'(2)) && (col_cur >= WW'(2));
		last      = (row_cur == eff_width - WW'(1)) && (col_cur == eff_width - WW'(1));
		col_inc   = col_cur + WW'(1);
		row_inc   = row_cur + WW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_inc >= eff_width) begin
				col_q <= '0;
				row_q <= (row_inc >= eff_width) ? '0 : row_inc[AW-1:0];
			end else begin
				col_q <= col_inc[AW-1:0];
				row_q <= row_cur[AW-1:0];
			end
		end
	end

	// s1: line buffer data arrives; write back and shift the window
	assign rd_eff = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign up_rd  = rd_eff[LW-1:PW];
	assign mid_rd = rd_eff[PW-1:0];
	assign wdata  = {mid_rd, px_s1};
	assign we     = valid_s1 && go_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1     <= col_cur[AW-1:0];
			px_s1       <= pixel;
			emit_s1     <= emit;
			last_s1     <= last;
			fwd_s1      <= we && (addr_s1 == col_cur[AW-1:0]);
			fwd_data_s1 <= wdata;
		end
	end

	ssm_ram #(
		.WIDTH (LW),
		.DEPTH (ssm_pkg::MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1),
		.wdata (wdata),
		.re    (accept),
		.raddr (col_cur[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (we) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= up_rd;
			win_q[1][2] <= mid_rd;
			win_q[2][2] <= px_s1;
		end
	end

	// s2: sums over the shifted window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go_s2) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			taps_s2.corners <= SW'(win_q[0][1]) + SW'(up_rd) + SW'(win_q[2][1]) + SW'(px_s1);
			taps_s2.edges   <= SW'(win_q[0][2]) + SW'(win_q[2][2]) + SW'(win_q[1][1])
			                 + SW'(mid_rd);
			taps_s2.centre  <= win_q[1][2];
			taps_s2.last    <= last_s1;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/ssm_mac.sv
// Weighting, rounding and saturation stages plus the output register.
// Depends on ssm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssm_mac (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        valid_s2,
	input  wire ssm_pkg::taps_t              taps_s2,
	output logic                             take_s2,
	input  wire ssm_pkg::weights_t           weights,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [ssm_pkg::PIX_W-1:0]        out_data,
	output logic                             out_last
);

	localparam int PRW = ssm_pkg::PROD_W;
	localparam int TW  = ssm_pkg::TOTAL_W;
	localparam int PW  = ssm_pkg::PIX_W;

	logic                  go_out, go_s3;
	logic                  valid_s3, last_s3;
	logic signed [PRW-1:0] p_corner_s3, p_edge_s3, p_centre_s3;
	logic signed [PRW-1:0] p_corner, p_edge, p_centre;
	logic signed [TW-1:0]  total;
	logic [PW-1:0]         sat;

	assign go_out  = !out_valid || out_ready;
	assign go_s3   = !valid_s3 || go_out;
	assign take_s2 = go_s3;

	assign p_corner = weights.corner * $signed({1'b0, taps_s2.corners});
	assign p_edge   = weights.edge_w * $signed({1'b0, taps_s2.edges});
	assign p_centre = weights.centre * $signed({1'b0, taps_s2.centre});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (go_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && go_s3) begin
			p_corner_s3 <= p_corner;
			p_edge_s3   <= p_edge;
			p_centre_s3 <= p_centre;
			last_s3     <= taps_s2.last;
		end
	end

	// round half up, clamp to the unsigned sample range
	always_comb begin
		total = TW'(p_corner_s3) + TW'(p_edge_s3) + TW'(p_centre_s3) + TW'(32768);
		if (total[TW-1]) begin
			sat = '0;
		end else if (|total[TW-2:2*PW]) begin
			sat = '1;
		end else begin
			sat = total[2*PW-1:PW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (go_out) begin
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && go_out) begin
			out_data <= sat;
			out_last <= last_s3;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/stencil_smoother_3x3.sv
// Top level of the 3x3 stencil smoother: register port and stream channels.
// Depends on ssm_pkg, ssm_front and ssm_mac.
//
// Usage. Pixels of a square image enter in raster order on the s_axis beat
// channel, one 16-bit unsigned sample per beat; tuser marks the first pixel
// of a frame and restarts the row and column counters. For every interior
// position one smoothed sample leaves on m_axis, tlast high on the last
// interior result of the frame. Border positions produce no beat.
// Throughput: one pixel per cycle unless the output stalls. The line buffer is a single RAM holding
// both previous rows, read once and written once per pixel; a pixel revisiting
// the entry being written in the same cycle takes forwarded data.
// Path: the result for position (r-1, c-1) passes the s1, s2 and s3 registers
// and the output register to m_axis after the pixel at (r, c) is accepted.
// Reset clears the counters, window and pipeline; the line buffer needs no
// clearing since every entry is written in the first two rows of a frame
// before it is used. Registers take their documented reset values.
// Stall: when m_axis_tready is low the pipeline fills its empty stages and
// s_axis_tready drops only once every stage holds a beat.
// Write configuration only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module stencil_smoother_3x3 (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [ssm_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [15:0]                  s_axis_tdata,   // [15:0] pixel
	input  wire logic                         s_axis_tuser,   // [0] frame_start
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [15:0]                       m_axis_tdata,   // [15:0] smoothed
	output logic                              m_axis_tlast
);

	localparam int WW  = ssm_pkg::WIDTH_W;
	localparam int WTW = ssm_pkg::WEIGHT_W;

	logic [WW-1:0]     image_width_q, eff_width_q, new_width;
	ssm_pkg::weights_t weights_q;
	ssm_pkg::reg_idx_t reg_idx;
	logic              wr_en;

	logic              valid_s2, take_s2;
	ssm_pkg::taps_t    taps_s2;

	assign pready    = 1'b1;
	assign reg_idx   = ssm_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en     = psel && penable && pwrite && pready;
	assign new_width = pwdata[WW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q    <= ssm_pkg::WIDTH_RESET;
			eff_width_q      <= ssm_pkg::WIDTH_RESET;
			weights_q.corner <= ssm_pkg::CORNER_RESET;
			weights_q.edge_w <= ssm_pkg::EDGE_RESET;
			weights_q.centre <= ssm_pkg::CENTRE_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				ssm_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= new_width;
					if (new_width < ssm_pkg::WIDTH_MIN) begin
						eff_width_q <= ssm_pkg::WIDTH_MIN;
					end else if (new_width > ssm_pkg::WIDTH_MAX) begin
						eff_width_q <= ssm_pkg::WIDTH_MAX;
					end else begin
						eff_width_q <= new_width;
					end
				end
				ssm_pkg::REG_CORNER_WEIGHT: weights_q.corner <= pwdata[WTW-1:0];
				ssm_pkg::REG_EDGE_WEIGHT:   weights_q.edge_w <= pwdata[WTW-1:0];
				ssm_pkg::REG_CENTRE_WEIGHT: weights_q.centre <= pwdata[WTW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ssm_pkg::REG_IMAGE_WIDTH:   prdata = 32'(image_width_q);
			ssm_pkg::REG_CORNER_WEIGHT: prdata = 32'(weights_q.corner);
			ssm_pkg::REG_EDGE_WEIGHT:   prdata = 32'(weights_q.edge_w);
			ssm_pkg::REG_CENTRE_WEIGHT: prdata = 32'(weights_q.centre);
			default:                    prdata = '0;
		endcase
	end

	ssm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.pixel       (s_axis_tdata),
		.frame_start (s_axis_tuser),
		.eff_width   (eff_width_q),
		.take_s2     (take_s2),
		.valid_s2    (valid_s2),
		.taps_s2     (taps_s2)
	);

	ssm_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.taps_s2   (taps_s2),
		.take_s2   (take_s2),
		.weights   (weights_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
`default_nettype wire
